// File: rtl/csab_pkg.sv
// Shared constants, types and helpers for the cross stencil average blur.
// No dependencies; used by the top level and the port checker.
package csab_pkg;

  localparam int MaxWidth    = 128;
  localparam int ColW        = $clog2(MaxWidth);
  localparam int HeightLimit = 4096;
  localparam int RowW        = $clog2(HeightLimit);
  localparam int PixW        = 8;
  localparam int WidthCfgW   = 8;
  localparam int HeightCfgW  = 13;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 13;
  localparam int SumW        = 11;

  // Result queue geometry
  localparam int QueueDepth  = 4;
  localparam int QPtrW       = $clog2(QueueDepth);
  localparam int QCntW       = $clog2(QueueDepth + 1);

  // floor(x / 5) == (x * 6554) >> 15 for x below 2048
  localparam int RecipFifth  = 6554;
  localparam int RecipShift  = 15;
  localparam int ProdW       = 25;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            run_end;
    logic            frame_end;
  } result_t;

  // Divide by five, rounding up when the remainder is three or more
  function automatic logic [PixW-1:0] round_fifth(input logic [SumW-1:0] sum);
    logic [SumW:0]    biased;
    logic [ProdW-1:0] prod;
    biased = {1'b0, sum} + (SumW+1)'(2);
    prod   = ProdW'(biased) * ProdW'(RecipFifth);
    return prod[RecipShift +: PixW];
  endfunction

endpackage

// File: rtl/cross_stencil_average_blur.sv
// Results are registered into the result queue as their pixel is accepted and leave from its head.
// Throughput: one pixel per cycle while in_stall_o is low; on the last row of a frame taller than one
// row each pixel yields two results, so there the four-entry result queue drains at one result per cycle.
// Reset: counters, result queue and left neighbor clear; width and height return to
// 128; line stores are not cleared (their contents are rewritten before use).
module cross_stencil_average_blur
  import csab_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PixW-1:0]       pixel_in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PixW-1:0]       pixel_out_o,
  output logic                  run_end_o,
  output logic                  frame_end_o
);

  // Configuration registers
  logic [WidthCfgW-1:0]  frame_width_q;
  logic [HeightCfgW-1:0] frame_height_q;
  logic [WidthCfgW-1:0]  w_eff;
  logic [HeightCfgW-1:0] h_eff;

  // Position and neighbor state
  logic [ColW-1:0] col_q, col_d, next_col, next_col1;
  logic [RowW-1:0] row_q, row_d;
  logic [PixW-1:0] left_q;
  logic [PixW-1:0] first_center_q;
  logic [PixW-1:0] mid_q, right_q, up_q;
  logic [PixW-1:0] mid_cur;

  // Line stores
  logic [PixW-1:0] above_mem  [MaxWidth];
  logic [PixW-1:0] center_mem [MaxWidth];

  // Result queue
  result_t         queue_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q, count_d;

  logic            in_acc, pop;
  logic            last_col, last_row, interior, has_first, has_second;
  logic [SumW-1:0] sum;
  logic [PixW-1:0] blurred;
  result_t         res_first, res_second;
  logic [QCntW-1:0] push_n;

  assign in_acc = in_valid_i && !in_stall_o;

  // Clamp configured sizes into range
  always_comb begin
    if (frame_width_q == '0) begin
      w_eff = WidthCfgW'(1);
    end else if (frame_width_q > WidthCfgW'(MaxWidth)) begin
      w_eff = WidthCfgW'(MaxWidth);
    end else begin
      w_eff = frame_width_q;
    end
    if (frame_height_q == '0) begin
      h_eff = HeightCfgW'(1);
    end else if (frame_height_q > HeightCfgW'(HeightLimit)) begin
      h_eff = HeightCfgW'(HeightLimit);
    end else begin
      h_eff = frame_height_q;
    end
  end

  assign last_col  = ({1'b0, col_q} + WidthCfgW'(1)) == w_eff;
  assign last_row  = ({1'b0, row_q} + HeightCfgW'(1)) == h_eff;
  assign next_col  = last_col ? '0 : col_q + ColW'(1);
  assign next_col1 = next_col + ColW'(1);

  // Center pixel: column 0 comes from its own register, others from the prefetch
  assign mid_cur = (col_q == '0) ? first_center_q : mid_q;

  // Stencil sum and rounding
  assign interior = (row_q >= RowW'(2)) && (col_q != '0) && !last_col;
  assign sum = SumW'(mid_cur) + SumW'(up_q) + SumW'(pixel_in_i) + SumW'(left_q)
             + SumW'(right_q);
  assign blurred = interior ? round_fifth(sum) : mid_cur;

  assign has_first  = (row_q != '0);
  assign has_second = last_row;

  assign res_first.pixel      = blurred;
  assign res_first.run_end    = !last_row;
  assign res_first.frame_end  = 1'b0;
  assign res_second.pixel     = pixel_in_i;
  assign res_second.run_end   = 1'b1;
  assign res_second.frame_end = last_col;

  assign push_n = in_acc ? (QCntW'(has_first) + QCntW'(has_second)) : '0;

  // Configuration writes and frame position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      col_d = next_col;
      if (last_col) begin
        row_d = last_row ? '0 : row_q + RowW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= WidthCfgW'(MaxWidth);
      frame_height_q <= HeightCfgW'(128);
      col_q          <= '0;
      row_q          <= '0;
      left_q         <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_WIDTH: begin
          frame_width_q <= cfg_data_i[WidthCfgW-1:0];
          col_q         <= '0;
          row_q         <= '0;
          left_q        <= '0;
        end
        CFG_FRAME_HEIGHT: begin
          frame_height_q <= cfg_data_i;
          col_q          <= '0;
          row_q          <= '0;
          left_q         <= '0;
        end
        default: begin
        end
      endcase
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (in_acc) begin
        left_q <= mid_cur;
      end
    end
  end

  // Line stores with prefetch of the next column's neighbors (write-first bypass)
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      above_mem[col_q]  <= mid_cur;
      center_mem[col_q] <= pixel_in_i;
      up_q    <= (next_col == col_q) ? mid_cur : above_mem[next_col];
      right_q <= (next_col1 == col_q) ? pixel_in_i : center_mem[next_col1];
      mid_q   <= right_q;
      if (col_q == '0) begin
        first_center_q <= pixel_in_i;
      end
    end
  end

  // Result queue storage
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (has_first) begin
        queue_q[wr_ptr_q] <= res_first;
        if (has_second) begin
          queue_q[wr_ptr_q + QPtrW'(1)] <= res_second;
        end
      end else if (has_second) begin
        queue_q[wr_ptr_q] <= res_second;
      end
    end
  end

  // Result queue control
  assign pop     = out_valid_o && !out_stall_i;
  assign count_d = count_q + push_n - QCntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrW'(push_n);
      rd_ptr_q <= rd_ptr_q + QPtrW'(pop);
      count_q  <= count_d;
    end
  end

  assign in_stall_o  = count_q > QCntW'(QueueDepth - 2);
  assign out_valid_o = count_q != '0;
  assign pixel_out_o = queue_q[rd_ptr_q].pixel;
  assign run_end_o   = queue_q[rd_ptr_q].run_end;
  assign frame_end_o = queue_q[rd_ptr_q].frame_end;

endmodule

// File: rtl/csab_checker.sv
// Port-level checks for the cross stencil average blur, bound to the top level.
// Depends on csab_pkg for field widths.
module csab_checker
  import csab_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [PixW-1:0]     pixel_out_o,
  input logic                run_end_o,
  input logic                frame_end_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_out_o)
      && $stable(run_end_o) && $stable(frame_end_o))
    else $error("stalled result changed");

  // The frame's last pixel is always the last result of its run
  a_frame_end_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> run_end_o)
    else $error("frame end without run end");

  // An empty queue never blocks input
  a_empty_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with no pending result");

  // Input stall persists while the output side is stalled
  a_stall_persist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && out_stall_i |=> in_stall_o)
    else $error("input stall released without a drained result");

endmodule

bind cross_stencil_average_blur csab_checker u_csab_checker (.*);
